### src/msmt_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// msmt_pkg: shared types and constants of the mass slice merge table
// Status codes, modes, register indexes, state and slice record types.
// ---------------------------------------------------------------------------
package msmt_pkg;

	localparam int SLICES = 1024;
	localparam int IDX_W  = $clog2(SLICES);
	localparam int CNT_W  = IDX_W + 1;

	typedef enum logic [2:0] {
		ST_MERGED   = 3'd0,
		ST_CREATED  = 3'd1,
		ST_FILTERED = 3'd2,
		ST_FULL     = 3'd3,
		ST_CLEARED  = 3'd4,
		ST_READ     = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		MODE_OBS   = 2'd0,
		MODE_CLEAR = 2'd1,
		MODE_READ  = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		REG_PPM     = 3'd0,
		REG_RT_HALF = 3'd1,
		REG_RT_LO   = 3'd2,
		REG_RT_HI   = 3'd3,
		REG_MZ_LO   = 3'd4,
		REG_MZ_HI   = 3'd5,
		REG_INT_LO  = 3'd6,
		REG_INT_HI  = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_WAIT,
		S_UPDATE,
		S_WRITE,
		S_READ,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic [19:0] key;
		logic [31:0] mz_min;
		logic [31:0] mz_max;
		logic [31:0] rt_min;
		logic [31:0] rt_max;
		logic [31:0] centre_mz;
		logic [31:0] centre_rt;
		logic [31:0] peak;
	} slice_t;

	// memory access request from sequencer to the table
	typedef struct packed {
		logic             rd;
		logic             wr;
		logic [IDX_W-1:0] addr;
		slice_t           data;
	} mem_req_t;

endpackage
`default_nettype wire

### src/msmt_table.sv
`default_nettype none
// ---------------------------------------------------------------------------
// msmt_table: slice record memory
// Single-port table of slice records, registered read data.
// ---------------------------------------------------------------------------
module msmt_table (
	input  wire                   clk,
	input  msmt_pkg::mem_req_t    req,
	output msmt_pkg::slice_t      rdata
);
	import msmt_pkg::*;

	slice_t mem [SLICES];

	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem[req.addr] <= req.data;
		end
		if (req.rd) begin
			rdata <= mem[req.addr];
		end
	end

endmodule
`default_nettype wire

### src/msmt_top_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// msmt_ctrl: slice scan sequencer
// Filters the beat, scans the table one entry a cycle through one shared
// compare unit, then merges or appends (unless full); read and clear beats skip the scan.
// ---------------------------------------------------------------------------
module msmt_ctrl (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	output logic                         busy,
	input  wire  [1:0]                   mode,
	input  wire  [3:0]                   ms_level,
	input  wire  [31:0]                  ret_time,
	input  wire  [31:0]                  mass_charge,
	input  wire  [31:0]                  intensity,
	input  wire  [9:0]                   read_index,
	input  wire  [23:0]                  ppm_factor,
	input  wire  [31:0]                  rt_half_window,
	input  wire  [31:0]                  rt_low,
	input  wire  [31:0]                  rt_high,
	input  wire  [31:0]                  mz_low,
	input  wire  [31:0]                  mz_high,
	input  wire  [31:0]                  intensity_low,
	input  wire  [31:0]                  intensity_high,
	output msmt_pkg::mem_req_t           req,
	input  msmt_pkg::slice_t             rdata,
	output logic                         done,
	output logic [2:0]                   status,
	output logic [9:0]                   slice_index,
	output logic [10:0]                  slice_count,
	output msmt_pkg::slice_t             res
);
	import msmt_pkg::*;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] scan_q;
	logic             rvalid_q;
	logic [IDX_W-1:0] raddr_q;
	logic             hit_q;
	logic [IDX_W-1:0] best_q;
	logic [31:0]      best_d_q;
	logic [31:0]      rt_q, mz_q, int_q;
	logic [19:0]      key_q;
	logic [31:0]      lo_q, hi_q, rlo_q, rhi_q;
	logic [9:0]       ridx_q;
	status_t          st_q;
	logic [IDX_W-1:0] idx_q;
	slice_t           res_q;
	logic             has_data_q;
	slice_t           upd_q;

	logic             pass;
	logic [35:0]      key_prod;
	logic [55:0]      win_prod;
	logic [31:0]      win;
	logic [32:0]      hi_sum, rhi_sum;
	logic             ent_hit;
	logic [31:0]      ent_d;

	function automatic logic in_rng(logic [31:0] v, logic [31:0] lo, logic [31:0] hi);
		return (hi == 32'd0) || (v >= lo && v <= hi);
	endfunction

	assign pass = (mode == MODE_OBS) && (ms_level == 4'd1) &&
		in_rng(ret_time, rt_low, rt_high) && in_rng(mass_charge, mz_low, mz_high) &&
		in_rng(intensity, intensity_low, intensity_high);
	assign key_prod = {4'd0, mass_charge} * 36'd10;
	assign win_prod = {24'd0, mass_charge} * {32'd0, ppm_factor};
	assign win      = win_prod[55:32] == 24'd0 ? 32'd0 : {8'd0, win_prod[55:32]};
	assign hi_sum   = {1'b0, mass_charge} + {1'b0, win};
	assign rhi_sum  = {1'b0, ret_time} + {1'b0, rt_half_window};

	// shared compare unit: one stored entry against the held observation
	assign ent_hit = (rdata.key == key_q) && (mz_q > rdata.mz_min) && (mz_q < rdata.mz_max)
		&& (rt_q > rdata.rt_min) && (rt_q < rdata.rt_max);
	assign ent_d   = rdata.mz_max - rdata.mz_min;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			rvalid_q <= 1'b0;
			hit_q    <= 1'b0;
			scan_q   <= '0;
		end else begin
			state_q  <= state_d;
			rvalid_q <= req.rd && (state_q == S_SCAN || state_q == S_READ);
			if (state_q == S_IDLE && start) begin
				scan_q <= '0;
				hit_q  <= 1'b0;
				if (mode == MODE_CLEAR) begin
					count_q <= '0;
				end
			end else if (state_q == S_SCAN && req.rd) begin
				scan_q <= scan_q + 1'b1;
			end
			if (rvalid_q && ent_hit && (!hit_q || ent_d < best_d_q)) begin
				hit_q <= 1'b1;
			end
			if (state_q == S_WRITE && !hit_q) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		raddr_q <= req.addr;
		if (state_q == S_IDLE && start) begin
			rt_q       <= ret_time;
			mz_q       <= mass_charge;
			int_q      <= intensity;
			key_q      <= key_prod[35:16];
			lo_q       <= mass_charge > win ? mass_charge - win : 32'd0;
			hi_q       <= hi_sum[32] ? 32'hFFFF_FFFF : hi_sum[31:0];
			rlo_q      <= ret_time > rt_half_window ? ret_time - rt_half_window : 32'd0;
			rhi_q      <= rhi_sum[32] ? 32'hFFFF_FFFF : rhi_sum[31:0];
			ridx_q     <= read_index;
			has_data_q <= 1'b0;
			idx_q      <= '0;
			case (mode)
				MODE_CLEAR: st_q <= ST_CLEARED;
				MODE_READ:  st_q <= ST_READ;
				MODE_OBS:   st_q <= pass ? ST_CREATED : ST_FILTERED;
				default:    st_q <= ST_FILTERED;
			endcase
		end
		if (rvalid_q && ent_hit && (!hit_q || ent_d < best_d_q)) begin
			best_q   <= raddr_q;
			best_d_q <= ent_d;
		end
		if (state_q == S_UPDATE) begin
			upd_q.key       <= key_q;
			upd_q.mz_min    <= lo_q;
			upd_q.mz_max    <= hi_q;
			upd_q.rt_min    <= (rlo_q < rdata.rt_min) ? rlo_q : rdata.rt_min;
			upd_q.rt_max    <= (rhi_q > rdata.rt_max) ? rhi_q : rdata.rt_max;
			upd_q.peak      <= (int_q > rdata.peak) ? int_q : rdata.peak;
			upd_q.centre_mz <= 32'({1'b0, lo_q} + {1'b0, hi_q} >> 1);
			upd_q.centre_rt <= 32'({1'b0, rdata.rt_min} + {1'b0, rdata.rt_max} >> 1);
		end
		if (state_q == S_WRITE) begin
			has_data_q <= 1'b1;
			if (hit_q) begin
				st_q  <= ST_MERGED;
				idx_q <= best_q;
				res_q <= req.data;
			end else begin
				st_q  <= ST_CREATED;
				idx_q <= count_q[IDX_W-1:0];
				res_q <= req.data;
			end
		end
		if (state_q == S_WAIT && st_q == ST_CREATED && !hit_q && count_q >= CNT_W'(SLICES)) begin
			st_q <= ST_FULL;
		end
		if (state_q == S_READ && rvalid_q) begin
			res_q      <= rdata;
			has_data_q <= {1'b0, ridx_q} < count_q;
		end
	end

	// centre_rt for a merge is taken from the widened window
	slice_t wr_data;
	always_comb begin
		wr_data = upd_q;
		wr_data.centre_rt = 32'(({1'b0, upd_q.rt_min} + {1'b0, upd_q.rt_max}) >> 1);
		if (!hit_q) begin
			wr_data.key       = key_q;
			wr_data.mz_min    = lo_q;
			wr_data.mz_max    = hi_q;
			wr_data.rt_min    = rlo_q;
			wr_data.rt_max    = rhi_q;
			wr_data.centre_mz = mz_q;
			wr_data.centre_rt = rt_q;
			wr_data.peak      = int_q;
		end
	end

	always_comb begin
		state_d  = state_q;
		req      = '0;
		req.data = wr_data;
		busy     = state_q != S_IDLE;
		done     = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (mode == MODE_READ) begin
						state_d = S_READ;
					end else if (mode == MODE_OBS && pass) begin
						state_d = S_SCAN;
					end else begin
						state_d = S_EMIT;
					end
				end
			end
			S_SCAN: begin
				if (scan_q < count_q) begin
					req.rd   = 1'b1;
					req.addr = scan_q[IDX_W-1:0];
				end else begin
					state_d = S_WAIT;
				end
			end
			S_WAIT: begin
				// the last compare has already landed in hit_q and best_q
				if (hit_q || (rvalid_q && ent_hit)) begin
					state_d = S_UPDATE;
				end else if (count_q >= CNT_W'(SLICES)) begin
					state_d = S_EMIT;
				end else begin
					state_d = S_WRITE;
				end
				req.rd   = 1'b1;
				req.addr = (rvalid_q && ent_hit && (!hit_q || ent_d < best_d_q)) ?
					raddr_q : best_q;
			end
			S_UPDATE: state_d = S_WRITE;
			S_WRITE: begin
				req.wr   = 1'b1;
				req.addr = hit_q ? best_q : count_q[IDX_W-1:0];
				state_d  = S_EMIT;
			end
			S_READ: begin
				req.rd   = !rvalid_q;
				req.addr = ridx_q;
				if (rvalid_q) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				done    = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign status      = st_q;
	assign slice_index = st_q == ST_READ ? ridx_q :
		(st_q == ST_MERGED || st_q == ST_CREATED) ? 10'(idx_q) : 10'd0;
	assign slice_count = 11'(count_q);
	assign res         = has_data_q ? res_q : '0;

	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(SLICES)) else $error("slice count overflow");
	a_no_rw: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.rd && req.wr)) else $error("read and write together");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done while idle");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("not idle after done");

endmodule
`default_nettype wire

### src/mass_slice_merge_table_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mass_slice_merge_table_top: mass slice merge table
// Builds m/z by rt slices from a stream of spectrum observations.
// ---------------------------------------------------------------------------
// Usage:
//  Drive the item fields and pulse start while busy is low; the beat is
//  taken on that edge. busy stays high until the result beat, which is
//  shown for one cycle with done high and cannot be held off.
//  An observation that passes the filter scans every held slice, one per
//  cycle, through one compare unit on the single table port.
//  Configuration beats (cfg_valid, cfg_index, cfg_data) are taken at once
//  (cfg_ready is always high) and must only be sent while the block is idle.
//  Reset empties the table (count to zero) and loads the register defaults;
//  no clearing pass is needed.
// ---------------------------------------------------------------------------
module mass_slice_merge_table_top (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire  [1:0]  mode,
	input  wire  [3:0]  ms_level,
	input  wire  [31:0] ret_time,
	input  wire  [31:0] mass_charge,
	input  wire  [31:0] intensity,
	input  wire  [9:0]  read_index,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [2:0]  cfg_index,
	input  wire  [31:0] cfg_data,
	output logic        done,
	output logic [2:0]  status,
	output logic [9:0]  slice_index,
	output logic [10:0] slice_count,
	output logic [31:0] win_mz_min,
	output logic [31:0] win_mz_max,
	output logic [31:0] win_rt_min,
	output logic [31:0] win_rt_max,
	output logic [31:0] centre_mz,
	output logic [31:0] centre_rt,
	output logic [31:0] peak_intensity
);
	import msmt_pkg::*;

	logic [23:0] ppm_q;
	logic [31:0] rt_half_q, rt_lo_q, rt_hi_q, mz_lo_q, mz_hi_q, int_lo_q, int_hi_q;
	mem_req_t    req;
	slice_t      rdata, res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppm_q     <= 24'd42950;
			rt_half_q <= 32'd262144;
			rt_lo_q   <= '0;
			rt_hi_q   <= '0;
			mz_lo_q   <= '0;
			mz_hi_q   <= '0;
			int_lo_q  <= '0;
			int_hi_q  <= '0;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_PPM:     ppm_q     <= cfg_data[23:0];
				REG_RT_HALF: rt_half_q <= cfg_data;
				REG_RT_LO:   rt_lo_q   <= cfg_data;
				REG_RT_HI:   rt_hi_q   <= cfg_data;
				REG_MZ_LO:   mz_lo_q   <= cfg_data;
				REG_MZ_HI:   mz_hi_q   <= cfg_data;
				REG_INT_LO:  int_lo_q  <= cfg_data;
				REG_INT_HI:  int_hi_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	msmt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.mode(mode), .ms_level(ms_level), .ret_time(ret_time),
		.mass_charge(mass_charge), .intensity(intensity), .read_index(read_index),
		.ppm_factor(ppm_q), .rt_half_window(rt_half_q), .rt_low(rt_lo_q),
		.rt_high(rt_hi_q), .mz_low(mz_lo_q), .mz_high(mz_hi_q),
		.intensity_low(int_lo_q), .intensity_high(int_hi_q),
		.req(req), .rdata(rdata), .done(done), .status(status),
		.slice_index(slice_index), .slice_count(slice_count), .res(res)
	);

	msmt_table u_table (
		.clk(clk), .req(req), .rdata(rdata)
	);

	assign win_mz_min     = res.mz_min;
	assign win_mz_max     = res.mz_max;
	assign win_rt_min     = res.rt_min;
	assign win_rt_max     = res.rt_max;
	assign centre_mz      = res.centre_mz;
	assign centre_rt      = res.centre_rt;
	assign peak_intensity = res.peak;

endmodule
`default_nettype wire
